FILE: rtl/pqnp_pkg.sv
`timescale 1ns / 1ps

package pqnp_pkg;

  // palette geometry
  localparam int unsigned IdxW        = 4;
  localparam int unsigned NumSlots    = 2 ** IdxW;
  localparam int unsigned PaletteSize = 16;  // searched entries, 2 to NumSlots
  localparam int unsigned ColorW      = 8;

  // squared distance on 3/3/2-bit components: at most 49 + 49 + 9
  localparam int unsigned DistW = 7;

  // alpha below this is transparent
  localparam logic [ColorW-1:0] AlphaThreshold = 8'd128;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PALETTE_LOW  = 2'd0,
    CFG_PALETTE_HIGH = 2'd1,
    CFG_TRANSPARENT  = 2'd2
  } cfg_reg_e;

  // RGB332 palette, entry k in slot k
  typedef logic [NumSlots-1:0][ColorW-1:0] palette_t;

  // quantized pixel handed from the front stage to the packer
  typedef struct packed {
    logic            valid;
    logic            row_end;
    logic [IdxW-1:0] index;
  } pqnp_item_t;

endpackage

FILE: rtl/pqnp_quantize.sv
`timescale 1ns / 1ps

module pqnp_quantize import pqnp_pkg::*; (
  input  logic [ColorW-1:0] red_i,
  input  logic [ColorW-1:0] green_i,
  input  logic [ColorW-1:0] blue_i,
  input  logic [ColorW-1:0] alpha_i,
  input  palette_t          palette_i,
  input  logic [IdxW-1:0]   transparent_i,
  output logic [IdxW-1:0]   index_o
);

  function automatic logic [2:0] abs_diff3(input logic [2:0] a, input logic [2:0] b);
    abs_diff3 = (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [5:0] square3(input logic [2:0] a);
    square3 = 6'(a * a);
  endfunction

  logic [DistW-1:0] lvl_dist [0:IdxW][NumSlots];
  logic [IdxW-1:0]  lvl_idx  [0:IdxW][NumSlots];
  logic             lvl_ok   [0:IdxW][NumSlots];

  always_comb begin
    logic [2:0] pr;
    logic [2:0] pg;
    logic [1:0] pb;
    logic [2:0] dr;
    logic [2:0] dg;
    logic [1:0] db;
    logic       take_b;

    pr = red_i[7:5];
    pg = green_i[7:5];
    pb = blue_i[7:6];

    for (int l = 0; l <= IdxW; l++) begin
      for (int n = 0; n < NumSlots; n++) begin
        lvl_dist[l][n] = '0;
        lvl_idx[l][n]  = '0;
        lvl_ok[l][n]   = 1'b0;
      end
    end

    // leaf distances, one per palette slot
    for (int k = 0; k < NumSlots; k++) begin
      dr = abs_diff3(pr, palette_i[k][7:5]);
      dg = abs_diff3(pg, palette_i[k][4:2]);
      db = (pb >= palette_i[k][1:0]) ? (pb - palette_i[k][1:0])
                                     : (palette_i[k][1:0] - pb);
      lvl_dist[0][k] = DistW'(square3(dr)) + DistW'(square3(dg))
                     + DistW'(db * db);
      lvl_idx[0][k]  = IdxW'(k);
      lvl_ok[0][k]   = (k < PaletteSize) && (IdxW'(k) != transparent_i);
    end

    // minimum tree, lower index kept on a tie
    for (int l = 0; l < IdxW; l++) begin
      for (int n = 0; n < (NumSlots >> (l + 1)); n++) begin
        take_b = lvl_ok[l][2*n+1] &&
                 (!lvl_ok[l][2*n] || (lvl_dist[l][2*n+1] < lvl_dist[l][2*n]));
        lvl_ok[l+1][n]   = lvl_ok[l][2*n] || lvl_ok[l][2*n+1];
        lvl_dist[l+1][n] = take_b ? lvl_dist[l][2*n+1] : lvl_dist[l][2*n];
        lvl_idx[l+1][n]  = take_b ? lvl_idx[l][2*n+1]  : lvl_idx[l][2*n];
      end
    end

    // an exact match has distance zero, so the nearest search covers it
    if (alpha_i < AlphaThreshold) begin
      index_o = transparent_i;
    end else if (lvl_ok[IdxW][0]) begin
      index_o = lvl_idx[IdxW][0];
    end else begin
      index_o = '0;
    end
  end

endmodule

FILE: rtl/pqnp_pack.sv
`timescale 1ns / 1ps

module pqnp_pack import pqnp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pqnp_item_t  item_i,
  output logic        item_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  packed_byte_o,
  output logic        row_done_o
);

  logic            odd_q, odd_d;
  logic [IdxW-1:0] pending_q, pending_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            row_done_q, row_done_d;
  logic            advance;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign advance      = item_i.valid && item_ready_o;

  always_comb begin
    odd_d       = odd_q;
    pending_d   = pending_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    row_done_d  = row_done_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      if (!odd_q) begin
        // even pixel waits for its pair, dropped at a row end
        odd_d     = !item_i.row_end;
        pending_d = item_i.row_end ? '0 : item_i.index;
      end else begin
        out_valid_d = 1'b1;
        byte_d      = {item_i.index, pending_q};
        row_done_d  = item_i.row_end;
        odd_d       = 1'b0;
        pending_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q       <= 1'b0;
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      odd_q       <= odd_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    row_done_q <= row_done_d;
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;
  assign row_done_o    = row_done_q;

endmodule

FILE: rtl/palette_quantize_nibble_pack.sv
`timescale 1ns / 1ps

// 4-bit palette quantizer with nibble packing.
// input channel (in_valid_i / in_ready_o): one RGBA8888 pixel per item plus
// row_end_i marking the last pixel of a row. output channel (out_valid_o /
// out_ready_i): one packed byte per pixel pair, even pixel index in the low
// nibble, odd pixel index in the high nibble, row_done_o set when the odd
// pixel closed its row. an even pixel that ends a row is dropped.
// pixels with alpha below 128 take the transparent index; others are cut
// to RGB332 and matched to the nearest palette entry, lowest index on ties,
// the transparent slot never matched.
// an accepted pixel is quantized combinationally from the input register,
// and its byte (if it is an odd pixel) is registered in the result register.
// throughput: one pixel every cycle while the receiver takes bytes, through
// the single input register, the 16-way distance tree and the result register.
// a stalled receiver holds the byte in the result register; the input
// register takes one more pixel only if it is empty, then in_ready_o drops.
// reset clears the palette, transparent index, packing state and valids.
// config writes are taken any cycle but must only happen while idle.

module palette_quantize_nibble_pack import pqnp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // pixel input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ColorW-1:0]   red_i,
  input  logic [ColorW-1:0]   green_i,
  input  logic [ColorW-1:0]   blue_i,
  input  logic [ColorW-1:0]   alpha_i,
  input  logic                row_end_i,
  // packed byte output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          packed_byte_o,
  output logic                row_done_o,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [CfgDataW-1:0] pal_low_q, pal_high_q;
  logic [IdxW-1:0]     transparent_q;

  // input register
  logic              s1_valid_q, s1_valid_d;
  logic [ColorW-1:0] s1_red_q, s1_green_q, s1_blue_q, s1_alpha_q;
  logic              s1_row_end_q;

  logic       in_load;
  logic       item_ready;
  palette_t   palette;
  pqnp_item_t item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_low_q     <= '0;
      pal_high_q    <= '0;
      transparent_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PALETTE_LOW:  pal_low_q     <= cfg_data_i;
        CFG_PALETTE_HIGH: pal_high_q    <= cfg_data_i;
        CFG_TRANSPARENT:  transparent_q <= cfg_data_i[IdxW-1:0];
        default: ;  // unknown register, write ignored
      endcase
    end
  end

  // the input register frees up whenever its pixel moves on to the packer
  assign in_ready_o = !s1_valid_q || item_ready;
  assign in_load    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_load) begin
      s1_valid_d = 1'b1;
    end else if (item_ready) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_red_q     <= red_i;
      s1_green_q   <= green_i;
      s1_blue_q    <= blue_i;
      s1_alpha_q   <= alpha_i;
      s1_row_end_q <= row_end_i;
    end
  end

  assign palette = {pal_high_q, pal_low_q};

  assign item.valid   = s1_valid_q;
  assign item.row_end = s1_row_end_q;

  pqnp_quantize u_quantize (
    .red_i         (s1_red_q),
    .green_i       (s1_green_q),
    .blue_i        (s1_blue_q),
    .alpha_i       (s1_alpha_q),
    .palette_i     (palette),
    .transparent_i (transparent_q),
    .index_o       (item.index)
  );

  pqnp_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .item_ready_o  (item_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .row_done_o    (row_done_o)
  );

endmodule

FILE: rtl/pqnp_checker.sv
`timescale 1ns / 1ps

module pqnp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] packed_byte_o,
  input logic       row_done_o
);

  // a byte held back by the receiver stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(packed_byte_o) && $stable(row_done_o))
    else $error("stalled output byte changed");

  // input side only blocks behind a stalled full output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a fresh byte follows a pixel taken into the input register and passed to the packer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output byte without a recent pixel");

endmodule

bind palette_quantize_nibble_pack pqnp_checker u_checker (.*);

FILE: verif/tb_palette_quantize_nibble_pack.sv
`timescale 1ns / 1ps

module tb_palette_quantize_nibble_pack;
  import pqnp_pkg::*;

  // register index the block does not decode, writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CfgSpareIdx = 2'd3;

  // cycles for an accepted pixel to reach the packer once its byte has left
  localparam int unsigned SettleCycles = 6;
  // random phases, each with its own palette and transparent slot
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned ItemsPerPhase = 114;
  // phase run with both sides at full rate
  localparam int unsigned SteadyPhase   = 3;
  // phase where the sender stops mid-way until every byte is out
  localparam int unsigned HoldPhase     = 4;

  typedef struct {
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic [ColorW-1:0] alpha;
    logic              row_end;
  } pixel_t;

  typedef struct packed {
    logic [7:0] packed_val;
    logic       row_done;
  } pair_byte_t;

  // one directed pixel; typed rows carry the byte they must complete
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       typed;
    logic [7:0] want_byte;
    logic       want_done;
  } stim_row_t;

  // rows before ResetRows run on the reset palette (all black, slot 0 reserved),
  // so black matches slot 1 exactly and any other color ties down to slot 1
  localparam int unsigned ResetRows = 7;
  localparam int unsigned NumRows   = 20;
  localparam stim_row_t DirectedRows [NumRows] = '{
    // reset palette
    '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 8'h00, 1'b0},  // black, even
    '{8'd255, 8'd255, 8'd255, 8'd0,   1'b0, 1'b1, 8'h01, 1'b0},  // alpha 0 -> slot 0
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'h00, 1'b0},  // white, all tie
    '{8'd0,   8'd0,   8'd0,   8'd127, 1'b1, 1'b1, 8'h01, 1'b1},  // alpha 127, row end
    '{8'd12,  8'd34,  8'd56,  8'd128, 1'b1, 1'b0, 8'h00, 1'b0},  // lone even, dropped
    '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, 8'h00, 1'b0},  // transparent even
    '{8'd255, 8'd255, 8'd255, 8'd128, 1'b1, 1'b1, 8'h10, 1'b1},  // alpha 128 opaque
    // directed palette, slot 2 reserved
    '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 8'h00, 1'b0},  // red: skip 2, hit 15
    '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 8'h00, 1'b0},  // white in 1 and 7
    '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd1,   8'd2,   8'd3,   8'd128, 1'b0, 1'b0, 8'h00, 1'b0},  // low bits dropped
    '{8'd100, 8'd30,  8'd200, 8'd255, 1'b1, 1'b0, 8'h00, 1'b0},  // nearest, row end
    '{8'd200, 8'd200, 8'd40,  8'd255, 1'b1, 1'b0, 8'h00, 1'b0},  // lone even, dropped
    '{8'd128, 8'd64,  8'd32,  8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd96,  8'd160, 8'd64,  8'd255, 1'b0, 1'b0, 8'h00, 1'b0},  // equal distances
    '{8'd255, 8'd255, 8'd255, 8'd127, 1'b0, 1'b0, 8'h00, 1'b0},  // reserved slot
    '{8'd0,   8'd0,   8'd0,   8'd128, 1'b1, 1'b0, 8'h00, 1'b0},
    '{8'd255, 8'd0,   8'd255, 8'd255, 1'b0, 1'b0, 8'h00, 1'b0},
    '{8'd0,   8'd255, 8'd0,   8'd255, 1'b1, 1'b0, 8'h00, 1'b0}
  };

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ColorW-1:0]   red = '0;
  logic [ColorW-1:0]   green = '0;
  logic [ColorW-1:0]   blue = '0;
  logic [ColorW-1:0]   alpha = '0;
  logic                row_end = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [7:0]          packed_byte;
  logic                row_done;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // own copy of the block's settings and packing state
  palette_t        shade_table = '0;
  logic [IdxW-1:0] clear_slot = '0;
  logic            odd_pixel = 1'b0;
  logic [IdxW-1:0] held_nibble = '0;

  // bytes the block still owes, oldest first
  pair_byte_t bytes_due [$];
  int unsigned mismatches = 0;
  // both sides at full rate while set
  bit steady_flow = 1'b0;

  palette_quantize_nibble_pack dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .alpha_i      (alpha),
    .row_end_i    (row_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .packed_byte_o(packed_byte),
    .row_done_o   (row_done),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // palette index for an opaque pixel: exact RGB332 hit first, else nearest
  function automatic logic [IdxW-1:0] nearest_index(input logic [7:0] r, input logic [7:0] g,
                                                    input logic [7:0] b);
    logic [7:0]      want;
    logic [7:0]      e;
    logic [IdxW-1:0] pick;
    int              dr;
    int              dg;
    int              db;
    int              sq_dist;
    int              best_dist;
    bit              found;
    bit              have;
    want = {r[7:5], g[7:5], b[7:6]};
    pick = '0;
    found = 1'b0;
    have = 1'b0;
    best_dist = 0;
    for (int k = 0; k < PaletteSize; k++) begin
      if (!found && k != int'(clear_slot) && shade_table[k] == want) begin
        found = 1'b1;
        pick = IdxW'(k);
      end
    end
    for (int k = 0; k < PaletteSize; k++) begin
      if (!found && k != int'(clear_slot)) begin
        e = shade_table[k];
        dr = int'(r[7:5]) - int'(e[7:5]);
        dg = int'(g[7:5]) - int'(e[4:2]);
        db = int'(b[7:6]) - int'(e[1:0]);
        sq_dist = dr * dr + dg * dg + db * db;
        // strict less keeps the lowest index on ties
        if (!have || sq_dist < best_dist) begin
          have = 1'b1;
          best_dist = sq_dist;
          pick = IdxW'(k);
        end
      end
    end
    return pick;
  endfunction

  // advance the packing state by one accepted pixel
  task automatic absorb_pixel(input pixel_t px);
    logic [IdxW-1:0] idx;
    idx = (px.alpha < AlphaThreshold) ? clear_slot : nearest_index(px.red, px.green, px.blue);
    if (!odd_pixel) begin
      // an even pixel that ends its row has no partner and is dropped
      held_nibble = px.row_end ? '0 : idx;
      odd_pixel = !px.row_end;
    end else begin
      bytes_due.push_back({idx, held_nibble, px.row_end});
      odd_pixel = 1'b0;
      held_nibble = '0;
    end
  endtask

  // present one pixel after a random gap and hold it until taken
  task automatic send_pixel(input pixel_t px);
    while (!steady_flow && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    red      <= px.red;
    green    <= px.green;
    blue     <= px.blue;
    alpha    <= px.alpha;
    row_end  <= px.row_end;
    do @(posedge clk_i); while (!in_ready);
    absorb_pixel(px);
  endtask

  // stop sending and wait for every owed byte, then let the pipe settle
  task automatic drain;
    in_valid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one register write, with the enable dropped again before returning
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_PALETTE_LOW:  shade_table[7:0] = val;
      CFG_PALETTE_HIGH: shade_table[15:8] = val;
      CFG_TRANSPARENT:  clear_slot = val[IdxW-1:0];
      default: ;
    endcase
  endtask

  // random pixel, often built around a palette color to hit exact matches
  function automatic pixel_t random_pixel;
    pixel_t     px;
    logic [7:0] e;
    px.red   = 8'($urandom);
    px.green = 8'($urandom);
    px.blue  = 8'($urandom);
    if ($urandom_range(9) < 4) begin
      e = shade_table[$urandom_range(NumSlots - 1)];
      px.red[7:5]   = e[7:5];
      px.green[7:5] = e[4:2];
      px.blue[7:6]  = e[1:0];
    end
    px.alpha   = ($urandom_range(3) == 0) ? 8'($urandom_range(127)) :
                                            8'($urandom_range(255, 128));
    px.row_end = ($urandom_range(7) == 0);
    return px;
  endfunction

  // receiver stalls at random outside the steady stretch
  always @(posedge clk_i) begin
    out_ready <= steady_flow || ($urandom_range(99) >= 34);
  end

  // compare each taken byte with the oldest one owed
  always @(posedge clk_i) begin
    pair_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bytes_due.size() == 0) begin
        $display("%0t: unexpected byte %02h row_done %0b", $time, packed_byte, row_done);
        mismatches++;
      end else begin
        want = bytes_due.pop_front();
        if (packed_byte !== want.packed_val) begin
          $display("%0t: packed_byte expected %02h actual %02h", $time, want.packed_val,
                   packed_byte);
          mismatches++;
        end
        if (row_done !== want.row_done) begin
          $display("%0t: row_done expected %0b actual %0b", $time, want.row_done, row_done);
          mismatches++;
        end
      end
    end
  end

  initial begin
    pixel_t          px;
    stim_row_t       row;
    logic [CfgDataW-1:0] low_word;
    logic [CfgDataW-1:0] high_word;
    logic [CfgDataW-1:0] slot_word;

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed walk: reset palette first, then a hand-built one
    for (int i = 0; i < NumRows; i++) begin
      if (i == ResetRows) begin
        drain();
        // white in 1 and 7, red in 2 (reserved) and 15, black, green, blue and mixed colors elsewhere
        write_reg(CFG_PALETTE_LOW, 64'hFF92_6D03_1CE0_FF00);
        write_reg(CFG_PALETTE_HIGH, 64'hE0FC_1FE3_DBB6_4924);
        write_reg(CFG_TRANSPARENT, 64'h2);
        write_reg(CfgSpareIdx, 64'hDEAD_BEEF_0BAD_F00D);
      end
      row = DirectedRows[i];
      px.red     = row.red;
      px.green   = row.green;
      px.blue    = row.blue;
      px.alpha   = row.alpha;
      px.row_end = row.row_end;
      send_pixel(px);
      // typed rows replace the predicted byte with the hand-written one
      if (row.typed) bytes_due[bytes_due.size() - 1] = {row.want_byte, row.want_done};
    end

    // random phases: extremes of the palette first, then random ones
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: begin
          low_word  = '1;
          high_word = '1;
          slot_word = '1;  // upper bits must be masked off, slot 15
        end
        1: begin
          low_word  = '0;
          high_word = '0;
          slot_word = {$urandom, $urandom} & ~64'hF;
        end
        default: begin
          low_word  = {$urandom, $urandom};
          high_word = {$urandom, $urandom};
          slot_word = {$urandom, $urandom};
        end
      endcase
      write_reg(CFG_PALETTE_LOW, low_word);
      write_reg(CFG_PALETTE_HIGH, high_word);
      write_reg(CFG_TRANSPARENT, slot_word);
      write_reg(CfgSpareIdx, {$urandom, $urandom});
      steady_flow = (p == SteadyPhase);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (p == HoldPhase && n == ItemsPerPhase / 2) drain();
        send_pixel(random_pixel());
      end
      steady_flow = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS palette_quantize_nibble_pack");
    end else begin
      $display("FAIL palette_quantize_nibble_pack");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("FAIL palette_quantize_nibble_pack");
    $finish;
  end

endmodule
